### hw/rtl/rntt_pkg.sv
// Shared types and constants for the radix-2 number theoretic transform unit.
// Depends on nothing; rntt_arith and the top level import it.
package rntt_pkg;

	// Fixed field widths of the ports.
	localparam int CFG_W   = 64;
	localparam int FIELD_W = 64;
	localparam int IDX_W   = 10;
	localparam int OP_W    = 2;
	localparam int RIDX_W  = 2;
	localparam int LSZ_W   = 4;
	localparam int DIR_W   = 2;

	// Default sizing of the store and the datapath.
	localparam int DEF_LOG_MAX_SIZE = 10;
	localparam int DEF_DATA_WIDTH   = 64;

	// Register values after reset.
	localparam logic [CFG_W-1:0] RST_MODULUS  = 64'd998244353;
	localparam logic [CFG_W-1:0] RST_ROOT     = 64'd3;
	localparam logic [LSZ_W-1:0] RST_LOG_SIZE = 4'd3;
	localparam logic [DIR_W-1:0] RST_DIR      = 2'd0;

	// Request operations.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_XFORM = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic [RIDX_W-1:0] {
		REG_MODULUS   = 2'd0,
		REG_ROOT      = 2'd1,
		REG_LOG_SIZE  = 2'd2,
		REG_DIRECTION = 2'd3
	} reg_idx_t;

	// Transform directions.
	typedef enum logic [DIR_W-1:0] {
		DIR_FWD = 2'd0,
		DIR_BWD = 2'd1,
		DIR_INV = 2'd2
	} dir_t;

	// Operations of the bit-serial arithmetic unit.
	typedef enum logic {
		AR_MUL = 1'b0,
		AR_DIV = 1'b1
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_rsp_t;

endpackage

### hw/rtl/rntt_store.sv
// Coefficient store: one write port and one registered read port.
// Depends on nothing beyond its parameters.
module rntt_store #(
	parameter int AW = 10,
	parameter int W  = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [W-1:0]  wd,
	input  logic [AW-1:0] ra,
	output logic [W-1:0]  rd
);

	logic [W-1:0] mem [2**AW];

	// Write, and read with a bypass for a write to the same word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (we && (wa == ra)) begin
			rd <= wd;
		end else begin
			rd <= mem[ra];
		end
	end

endmodule

### hw/rtl/rntt_arith.sv
// Bit-serial modular multiplier and restoring divider sharing one control.
// Depends on rntt_pkg for the request and status structs.
module rntt_arith #(
	parameter int W = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rntt_pkg::arith_req_t req,
	input  logic [W-1:0]        a,
	input  logic [W-1:0]        b,
	input  logic [W-1:0]        m,
	output rntt_pkg::arith_rsp_t rsp,
	output logic [W-1:0]        prod,
	output logic [W-1:0]        quot,
	output logic [W-1:0]        rem
);
	import rntt_pkg::*;

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q, done_q, ph_q;
	arith_op_t        op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     acc_q, x_q, y_q, m_q;
	logic [W:0]       r_q;

	logic [W:0] add_s, add_r, div_s;
	logic       div_ge;
	logic       last;

	// One modular addition: doubling in phase zero, adding x in phase one.
	always_comb begin
		add_s = {1'b0, acc_q} + {1'b0, (ph_q ? x_q : acc_q)};
		add_r = (add_s >= {1'b0, m_q}) ? add_s - {1'b0, m_q} : add_s;
	end

	// One restoring division step: bring in the next dividend bit.
	always_comb begin
		div_s  = {r_q[W-1:0], y_q[W-1]};
		div_ge = (div_s >= {1'b0, x_q});
	end

	assign last = (cnt_q == CNT_W'(W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			op_q   <= AR_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				ph_q   <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				unique case (op_q)
					AR_MUL: begin
						ph_q <= ~ph_q;
						if (ph_q) begin
							cnt_q <= cnt_q + CNT_W'(1);
							if (last) begin
								busy_q <= 1'b0;
								done_q <= 1'b1;
							end
						end
					end
					AR_DIV: begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (last) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			r_q   <= '0;
			m_q   <= m;
			x_q   <= (req.op == AR_DIV) ? b : a;
			y_q   <= (req.op == AR_DIV) ? a : b;
		end else if (busy_q) begin
			unique case (op_q)
				AR_MUL: begin
					if (!ph_q) begin
						acc_q <= add_r[W-1:0];
					end else begin
						if (y_q[W-1]) begin
							acc_q <= add_r[W-1:0];
						end
						y_q <= {y_q[W-2:0], 1'b0};
					end
				end
				AR_DIV: begin
					r_q <= div_ge ? div_s - {1'b0, x_q} : div_s;
					y_q <= {y_q[W-2:0], div_ge};
				end
			endcase
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign prod     = acc_q;
	assign quot     = y_q;
	assign rem      = r_q[W-1:0];

endmodule

### hw/rtl/radix2_number_theoretic_transform_unit.sv
// Top level of the radix-2 NTT unit: request sequencer, registers, output stage.
// Depends on rntt_pkg, rntt_store and rntt_arith.
//
// Channel   Signals                                  Direction
// in        in_valid/in_ready, operation,index,value  request in
// out       out_valid/out_ready, word                  result out
// cfg       cfg_valid/cfg_ready, cfg_index,cfg_data    register write
//
// A load reduces its value with the divider, which makes the remainder one
// bit per cycle; with a modulus below two a load writes zero without the
// divider. A read goes through the registered store port. A transform's run
// time is set by the bit-serial multiplier, plus the reduction, power and
// inverse passes. Reset sets the registers to their defaults; the store is
// not cleared. A read whose result register is full waits for it.
module radix2_number_theoretic_transform_unit #(
	parameter int LOG_MAX_SIZE = rntt_pkg::DEF_LOG_MAX_SIZE,
	parameter int DATA_WIDTH   = rntt_pkg::DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rntt_pkg::OP_W-1:0]    operation,
	input  logic [rntt_pkg::IDX_W-1:0]   index,
	input  logic [rntt_pkg::FIELD_W-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rntt_pkg::FIELD_W-1:0] word,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rntt_pkg::RIDX_W-1:0]  cfg_index,
	input  logic [rntt_pkg::CFG_W-1:0]   cfg_data
);
	import rntt_pkg::*;

	localparam int W   = DATA_WIDTH;
	localparam int AW  = LOG_MAX_SIZE;
	localparam int CW  = AW + 1;
	localparam int LGW = $clog2(LOG_MAX_SIZE + 1);

	typedef enum logic [5:0] {
		S_IDLE, S_ARW, S_RWAIT, S_LD_PUT, S_RD_OUT,
		S_TZ, S_TR_RD, S_TR_DIV, S_TR_WR,
		S_PW_INIT, S_PW_BEG, S_PW_CHK, S_PW_R, S_PW_SQ, S_PW_P, S_PW_END,
		S_INV_CHK, S_INV_Q, S_INV_T, S_INV_B,
		S_BF_SPAN, S_BF_L, S_BF_K, S_BF_U, S_BF_V, S_BF_P, S_BF_W, S_BF_B,
		S_BR_I, S_BR_A, S_BR_B, S_BR_C,
		S_SC_INV, S_SC_RD, S_SC_M, S_SC_W
	} state_t;

	state_t st_q, aret_q, rret_q, iret_q;

	// Configuration registers.
	logic [W-1:0]     mod_q, root_q;
	logic [LSZ_W-1:0] lsz_q;
	logic [DIR_W-1:0] dir_q;

	// Sequencer registers.
	logic [CW-1:0] k_q, l_q, span_q, half_q, rv_q;
	logic [W-1:0]  u_q, w_q, base_q, p_q, pr_q, e_q;
	logic [W-1:0]  r0_q, r1_q, t0_q, t1_q, nr_q, inv_res_q;
	logic          out_valid_q;
	logic [W-1:0]  word_q;

	// Store and arithmetic unit connections.
	logic          we_q;
	logic [AW-1:0] wa_q, ra_q;
	logic [W-1:0]  wd_q, rd;
	arith_req_t    ar_req_q;
	arith_rsp_t    ar_rsp;
	logic [W-1:0]  ar_a_q, ar_b_q, ar_prod, ar_quot, ar_rem;

	// Derived values.
	logic [LGW-1:0] lg;
	logic [CW-1:0]  n, nm1, kh, rv;
	logic [AW-1:0]  kr_full;
	logic           small_m;
	logic [W-1:0]   e_init, bf_sum, bf_diff, q_red, nt;
	logic [W:0]     sum_w;

	// Transform length, saturated to the store size.
	always_comb begin
		if (32'(lsz_q) > LOG_MAX_SIZE) begin
			lg = LGW'(LOG_MAX_SIZE);
		end else begin
			lg = LGW'(lsz_q);
		end
		n   = CW'(1) << lg;
		nm1 = n - CW'(1);
	end

	assign small_m = (mod_q < W'(2));
	assign e_init  = (mod_q - W'(1)) >> lg;
	assign kh      = k_q + half_q;

	// Bit-reversed index over lg bits.
	always_comb begin
		for (int b = 0; b < AW; b++) begin
			kr_full[b] = k_q[AW-1-b];
		end
		rv = CW'(kr_full >> (AW - 32'(lg)));
	end

	// Butterfly sum and difference modulo the modulus.
	always_comb begin
		sum_w   = {1'b0, u_q} + {1'b0, rd};
		bf_sum  = (sum_w >= {1'b0, mod_q}) ? sum_w[W-1:0] - mod_q : sum_w[W-1:0];
		bf_diff = (u_q >= rd) ? u_q - rd : u_q - rd + mod_q;
	end

	// Euclid helpers: quotient reduced below the modulus, next Bezout term.
	assign q_red = (ar_quot >= mod_q) ? ar_quot - mod_q : ar_quot;
	assign nt    = (t0_q >= ar_prod) ? t0_q - ar_prod : t0_q - ar_prod + mod_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= W'(RST_MODULUS);
			root_q <= W'(RST_ROOT);
			lsz_q  <= RST_LOG_SIZE;
			dir_q  <= RST_DIR;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODULUS:   mod_q  <= cfg_data[W-1:0];
				REG_ROOT:      root_q <= cfg_data[W-1:0];
				REG_LOG_SIZE:  lsz_q  <= cfg_data[LSZ_W-1:0];
				REG_DIRECTION: dir_q  <= cfg_data[DIR_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: requests, transform passes and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			aret_q      <= S_IDLE;
			rret_q      <= S_IDLE;
			iret_q      <= S_IDLE;
			we_q        <= 1'b0;
			ar_req_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			we_q           <= 1'b0;
			ar_req_q.start <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						k_q <= '0;
						if (operation == OP_LOAD) begin
							wa_q <= AW'(index);
							if (small_m) begin
								we_q <= 1'b1;
								wd_q <= '0;
							end else begin
								ar_req_q <= '{start: 1'b1, op: AR_DIV};
								ar_a_q   <= value[W-1:0];
								ar_b_q   <= mod_q;
								aret_q   <= S_LD_PUT;
								st_q     <= S_ARW;
							end
						end else if (operation == OP_XFORM) begin
							st_q <= small_m ? S_TZ : S_TR_RD;
						end else if (operation == OP_READ) begin
							ra_q   <= AW'(index);
							rret_q <= S_RD_OUT;
							st_q   <= S_RWAIT;
						end
					end
				end
				S_ARW: begin
					if (ar_rsp.done) begin
						st_q <= aret_q;
					end
				end
				S_RWAIT: st_q <= rret_q;
				S_LD_PUT: begin
					we_q <= 1'b1;
					wd_q <= ar_rem;
					st_q <= S_IDLE;
				end
				S_RD_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						word_q      <= rd;
						st_q        <= S_IDLE;
					end
				end
				// Small modulus: every word in use becomes zero.
				S_TZ: begin
					we_q <= 1'b1;
					wa_q <= k_q[AW-1:0];
					wd_q <= '0;
					k_q  <= k_q + CW'(1);
					if (k_q == nm1) begin
						st_q <= S_IDLE;
					end
				end
				// Reduce each word in use modulo the current modulus.
				S_TR_RD: begin
					ra_q   <= k_q[AW-1:0];
					rret_q <= S_TR_DIV;
					st_q   <= S_RWAIT;
				end
				S_TR_DIV: begin
					ar_req_q <= '{start: 1'b1, op: AR_DIV};
					ar_a_q   <= rd;
					ar_b_q   <= mod_q;
					aret_q   <= S_TR_WR;
					st_q     <= S_ARW;
				end
				S_TR_WR: begin
					we_q <= 1'b1;
					wa_q <= k_q[AW-1:0];
					wd_q <= ar_rem;
					k_q  <= k_q + CW'(1);
					st_q <= (k_q == nm1) ? S_PW_INIT : S_TR_RD;
				end
				// Twiddle base by square and multiply.
				S_PW_INIT: begin
					e_q      <= e_init;
					ar_req_q <= '{start: 1'b1, op: AR_DIV};
					ar_a_q   <= root_q;
					ar_b_q   <= mod_q;
					aret_q   <= S_PW_BEG;
					st_q     <= S_ARW;
				end
				S_PW_BEG: begin
					p_q  <= ar_rem;
					pr_q <= W'(1);
					st_q <= S_PW_CHK;
				end
				S_PW_CHK: begin
					if (e_q == '0) begin
						st_q <= S_PW_END;
					end else if (e_q[0]) begin
						ar_req_q <= '{start: 1'b1, op: AR_MUL};
						ar_a_q   <= pr_q;
						ar_b_q   <= p_q;
						aret_q   <= S_PW_R;
						st_q     <= S_ARW;
					end else begin
						st_q <= S_PW_SQ;
					end
				end
				S_PW_R: begin
					pr_q <= ar_prod;
					st_q <= S_PW_SQ;
				end
				S_PW_SQ: begin
					ar_req_q <= '{start: 1'b1, op: AR_MUL};
					ar_a_q   <= p_q;
					ar_b_q   <= p_q;
					aret_q   <= S_PW_P;
					st_q     <= S_ARW;
				end
				S_PW_P: begin
					p_q  <= ar_prod;
					e_q  <= e_q >> 1;
					st_q <= S_PW_CHK;
				end
				S_PW_END: begin
					base_q <= pr_q;
					span_q <= n;
					if (dir_q == DIR_BWD || dir_q == DIR_INV) begin
						r0_q   <= mod_q;
						r1_q   <= pr_q;
						t0_q   <= '0;
						t1_q   <= W'(1);
						iret_q <= S_INV_B;
						st_q   <= S_INV_CHK;
					end else begin
						st_q <= S_BF_SPAN;
					end
				end
				// Extended Euclid; zero when the gcd is not one.
				S_INV_CHK: begin
					if (r1_q == '0) begin
						inv_res_q <= (r0_q == W'(1)) ? t0_q : '0;
						st_q      <= iret_q;
					end else begin
						ar_req_q <= '{start: 1'b1, op: AR_DIV};
						ar_a_q   <= r0_q;
						ar_b_q   <= r1_q;
						aret_q   <= S_INV_Q;
						st_q     <= S_ARW;
					end
				end
				S_INV_Q: begin
					nr_q     <= ar_rem;
					ar_req_q <= '{start: 1'b1, op: AR_MUL};
					ar_a_q   <= q_red;
					ar_b_q   <= t1_q;
					aret_q   <= S_INV_T;
					st_q     <= S_ARW;
				end
				S_INV_T: begin
					r0_q <= r1_q;
					r1_q <= nr_q;
					t0_q <= t1_q;
					t1_q <= nt;
					st_q <= S_INV_CHK;
				end
				S_INV_B: begin
					base_q <= inv_res_q;
					st_q   <= S_BF_SPAN;
				end
				// Decimation-in-frequency butterfly passes.
				S_BF_SPAN: begin
					if (span_q <= CW'(1)) begin
						k_q  <= '0;
						st_q <= S_BR_I;
					end else begin
						half_q <= span_q >> 1;
						w_q    <= W'(1);
						l_q    <= '0;
						st_q   <= S_BF_L;
					end
				end
				S_BF_L: begin
					if (l_q == half_q) begin
						ar_req_q <= '{start: 1'b1, op: AR_MUL};
						ar_a_q   <= base_q;
						ar_b_q   <= base_q;
						aret_q   <= S_BF_B;
						st_q     <= S_ARW;
					end else begin
						k_q  <= l_q;
						st_q <= S_BF_K;
					end
				end
				S_BF_K: begin
					if (k_q >= n) begin
						ar_req_q <= '{start: 1'b1, op: AR_MUL};
						ar_a_q   <= w_q;
						ar_b_q   <= base_q;
						aret_q   <= S_BF_W;
						st_q     <= S_ARW;
					end else begin
						ra_q   <= k_q[AW-1:0];
						rret_q <= S_BF_U;
						st_q   <= S_RWAIT;
					end
				end
				S_BF_U: begin
					u_q    <= rd;
					ra_q   <= kh[AW-1:0];
					rret_q <= S_BF_V;
					st_q   <= S_RWAIT;
				end
				S_BF_V: begin
					we_q     <= 1'b1;
					wa_q     <= k_q[AW-1:0];
					wd_q     <= bf_sum;
					ar_req_q <= '{start: 1'b1, op: AR_MUL};
					ar_a_q   <= w_q;
					ar_b_q   <= bf_diff;
					aret_q   <= S_BF_P;
					st_q     <= S_ARW;
				end
				S_BF_P: begin
					we_q <= 1'b1;
					wa_q <= kh[AW-1:0];
					wd_q <= ar_prod;
					k_q  <= k_q + span_q;
					st_q <= S_BF_K;
				end
				S_BF_W: begin
					w_q  <= ar_prod;
					l_q  <= l_q + CW'(1);
					st_q <= S_BF_L;
				end
				S_BF_B: begin
					base_q <= ar_prod;
					span_q <= span_q >> 1;
					st_q   <= S_BF_SPAN;
				end
				// Bit-reverse permutation by pairwise swaps.
				S_BR_I: begin
					if (k_q == n) begin
						if (dir_q == DIR_INV) begin
							ar_req_q <= '{start: 1'b1, op: AR_DIV};
							ar_a_q   <= W'(n);
							ar_b_q   <= mod_q;
							aret_q   <= S_SC_INV;
							st_q     <= S_ARW;
						end else begin
							st_q <= S_IDLE;
						end
					end else if (k_q < rv) begin
						rv_q   <= rv;
						ra_q   <= k_q[AW-1:0];
						rret_q <= S_BR_A;
						st_q   <= S_RWAIT;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_BR_A: begin
					u_q    <= rd;
					ra_q   <= rv_q[AW-1:0];
					rret_q <= S_BR_B;
					st_q   <= S_RWAIT;
				end
				S_BR_B: begin
					we_q <= 1'b1;
					wa_q <= k_q[AW-1:0];
					wd_q <= rd;
					st_q <= S_BR_C;
				end
				S_BR_C: begin
					we_q <= 1'b1;
					wa_q <= rv_q[AW-1:0];
					wd_q <= u_q;
					k_q  <= k_q + CW'(1);
					st_q <= S_BR_I;
				end
				// Inverse direction: scale every word by the inverse of n.
				S_SC_INV: begin
					r0_q   <= mod_q;
					r1_q   <= ar_rem;
					t0_q   <= '0;
					t1_q   <= W'(1);
					k_q    <= '0;
					iret_q <= S_SC_RD;
					st_q   <= S_INV_CHK;
				end
				S_SC_RD: begin
					if (k_q == n) begin
						st_q <= S_IDLE;
					end else begin
						ra_q   <= k_q[AW-1:0];
						rret_q <= S_SC_M;
						st_q   <= S_RWAIT;
					end
				end
				S_SC_M: begin
					ar_req_q <= '{start: 1'b1, op: AR_MUL};
					ar_a_q   <= rd;
					ar_b_q   <= inv_res_q;
					aret_q   <= S_SC_W;
					st_q     <= S_ARW;
				end
				S_SC_W: begin
					we_q <= 1'b1;
					wa_q <= k_q[AW-1:0];
					wd_q <= ar_prod;
					k_q  <= k_q + CW'(1);
					st_q <= S_SC_RD;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	rntt_store #(
		.AW (AW),
		.W  (W)
	) u_store (
		.clk (clk),
		.we  (we_q),
		.wa  (wa_q),
		.wd  (wd_q),
		.ra  (ra_q),
		.rd  (rd)
	);

	rntt_arith #(
		.W (W)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req_q),
		.a      (ar_a_q),
		.b      (ar_b_q),
		.m      (mod_q),
		.rsp    (ar_rsp),
		.prod   (ar_prod),
		.quot   (ar_quot),
		.rem    (ar_rem)
	);

	assign in_ready  = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign word      = FIELD_W'(word_q);

	// The arithmetic unit is never busy while a new request can enter.
	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ar_rsp.busy)
		else $error("arithmetic unit busy while accepting requests");

	// A finished arithmetic operation is always awaited by the sequencer.
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ar_rsp.done |-> (st_q == S_ARW))
		else $error("arithmetic result arrived with nobody waiting");

	// A result appears only from the read path.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(st_q) == S_RD_OUT))
		else $error("result raised outside of a read");

endmodule
